/* rtl/qbs_pkg.sv */
// Shared types and constants for the quote and bracket aware splitter.
// Used by every module in rtl/; depends on nothing else.
package qbs_pkg;

   // Default parameter values
   localparam int DEPTH_BITS_DEF = 8;
   localparam int COUNT_BITS_DEF = 16;

   // Width of the piece index and piece count result fields
   localparam int OUT_BITS = 16;

   // Delimiter after reset (semicolon)
   localparam logic [7:0] DELIM_RESET = 8'd59;

   // Character codes
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_BACKTICK  = 8'h60;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;

   // Byte-count saturation limit for the escape lookback
   localparam logic [1:0] POS_FULL = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]          out_byte;
      logic                ends_piece;
      logic [OUT_BITS-1:0] piece_index;
      logic [OUT_BITS-1:0] piece_count;
      logic                done_res;
   } rsp_payload_type;

endpackage

/* rtl/qbs_in_stage.sv */
// Input register of the splitter: holds one accepted item until the core takes it.
// Depends on qbs_pkg.
module qbs_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  qbs_pkg::req_payload_type req_payload,
   input  logic                     take,
   output logic                     s1_valid,
   output qbs_pkg::req_payload_type s1_payload
);

   logic                     valid_ff;
   logic                     valid_in;
   logic                     load;
   qbs_pkg::req_payload_type payload_ff;

   // Stall only while a held item is not moving on this cycle
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Track occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the item
   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= req_payload;
      end
   end

   assign s1_valid   = valid_ff;
   assign s1_payload = payload_ff;

endmodule

/* rtl/qbs_core.sv */
// Split state and per-byte decision logic: quote flag, bracket depth, piece counter.
// Depends on qbs_pkg.
module qbs_core #(
   parameter int DEPTH_BITS = qbs_pkg::DEPTH_BITS_DEF,
   parameter int COUNT_BITS = qbs_pkg::COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  qbs_pkg::req_payload_type item,
   input  logic [7:0]               delimiter,
   output qbs_pkg::rsp_payload_type result
);

   localparam int OutBits = qbs_pkg::OUT_BITS;
   localparam logic signed [DEPTH_BITS-1:0] DepthMax = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic signed [DEPTH_BITS-1:0] DepthMin = {1'b1, {(DEPTH_BITS-1){1'b0}}};
   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

   logic [7:0]                   prev_ff, prev_in;
   logic [7:0]                   prev_prev_ff, prev_prev_in;
   logic [1:0]                   pos_ff, pos_in;
   logic                         quote_ff, quote_in;
   logic signed [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [COUNT_BITS-1:0]        piece_ff, piece_in;

   logic                         is_quote;
   logic                         toggle;
   logic                         quote_new;
   logic signed [DEPTH_BITS-1:0] depth_new;
   logic                         ends;
   logic [COUNT_BITS-1:0]        piece_new;
   logic [COUNT_BITS:0]          count_sum;
   logic [COUNT_BITS-1:0]        count_sat;
   logic [OutBits-1:0]           index_out;
   logic [OutBits-1:0]           count_out;

   // Quote tracking: a single backslash escapes, a doubled one does not
   always_comb begin
      is_quote = (item.in_byte == qbs_pkg::CHAR_DQUOTE)
              || (item.in_byte == qbs_pkg::CHAR_SQUOTE)
              || (item.in_byte == qbs_pkg::CHAR_BACKTICK);
      toggle   = (pos_ff == 2'd0)
              || (prev_ff != qbs_pkg::CHAR_BACKSLASH)
              || ((pos_ff == qbs_pkg::POS_FULL) && (prev_prev_ff == qbs_pkg::CHAR_BACKSLASH));
      quote_new = (is_quote && toggle) ? !quote_ff : quote_ff;
   end

   // Bracket depth, saturating; then the split test on the updated depth
   always_comb begin
      depth_new = depth_ff;
      ends      = 1'b0;
      piece_new = piece_ff;
      if (!quote_new) begin
         if (((item.in_byte == qbs_pkg::CHAR_LPAREN)
              || (item.in_byte == qbs_pkg::CHAR_LBRACE)
              || (item.in_byte == qbs_pkg::CHAR_LBRACKET)) && (depth_ff != DepthMax)) begin
            depth_new = depth_ff + DEPTH_BITS'(1);
         end
         if (((item.in_byte == qbs_pkg::CHAR_RPAREN)
              || (item.in_byte == qbs_pkg::CHAR_RBRACE)
              || (item.in_byte == qbs_pkg::CHAR_RBRACKET)) && (depth_ff != DepthMin)) begin
            depth_new = depth_ff - DEPTH_BITS'(1);
         end
         if ((item.in_byte == delimiter) && (depth_new == '0)) begin
            ends = 1'b1;
            if (!item.is_last && (piece_ff != CountMax)) begin
               piece_new = piece_ff + COUNT_BITS'(1);
            end
         end
      end
   end

   // Piece count on the last byte, saturating
   always_comb begin
      count_sum = {1'b0, piece_ff} + (COUNT_BITS+1)'(1);
      count_sat = count_sum[COUNT_BITS] ? CountMax : count_sum[COUNT_BITS-1:0];
   end

   // Clamp or extend the counter to the result field width
   generate
      if (COUNT_BITS > OutBits) begin : g_clamp
         assign index_out = (|piece_ff[COUNT_BITS-1:OutBits]) ? {OutBits{1'b1}}
                                                               : piece_ff[OutBits-1:0];
         assign count_out = (|count_sat[COUNT_BITS-1:OutBits]) ? {OutBits{1'b1}}
                                                                : count_sat[OutBits-1:0];
      end else begin : g_extend
         assign index_out = OutBits'(piece_ff);
         assign count_out = OutBits'(count_sat);
      end
   endgenerate

   // Assemble the result
   always_comb begin
      result.out_byte    = item.in_byte;
      result.ends_piece  = ends;
      result.piece_index = index_out;
      result.piece_count = item.is_last ? count_out : '0;
      result.done_res    = item.is_last;
   end

   // Next state: on an advance, clear on the last byte, otherwise advance the history
   always_comb begin
      prev_in      = prev_ff;
      prev_prev_in = prev_prev_ff;
      pos_in       = pos_ff;
      quote_in     = quote_ff;
      depth_in     = depth_ff;
      piece_in     = piece_ff;
      if (advance) begin
         if (item.is_last) begin
            prev_in      = '0;
            prev_prev_in = '0;
            pos_in       = '0;
            quote_in     = 1'b0;
            depth_in     = '0;
            piece_in     = '0;
         end else begin
            prev_prev_in = prev_ff;
            prev_in      = item.in_byte;
            pos_in       = (pos_ff == qbs_pkg::POS_FULL) ? pos_ff : pos_ff + 2'd1;
            quote_in     = quote_new;
            depth_in     = depth_new;
            piece_in     = piece_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         prev_prev_ff <= '0;
         pos_ff       <= '0;
         quote_ff     <= 1'b0;
         depth_ff     <= '0;
         piece_ff     <= '0;
      end else begin
         prev_ff      <= prev_in;
         prev_prev_ff <= prev_prev_in;
         pos_ff       <= pos_in;
         quote_ff     <= quote_in;
         depth_ff     <= depth_in;
         piece_ff     <= piece_in;
      end
   end

   // State returns to idle after the last byte of a string
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && item.is_last) |=>
         (depth_ff == '0) && (piece_ff == '0) && !quote_ff && (pos_ff == 2'd0))
      else $error("split state not cleared after last byte");

   // The piece counter only moves upward inside a string
   a_piece_monotonic: assert property (@(posedge clock) disable iff (reset)
      (advance && !item.is_last) |=> (piece_ff >= $past(piece_ff)))
      else $error("piece counter went backward");

   // Only a quote character can flip the quote flag
   a_quote_only_on_quote: assert property (@(posedge clock) disable iff (reset)
      (advance && !item.is_last && !is_quote) |=> (quote_ff == $past(quote_ff)))
      else $error("quote flag changed on a non-quote byte");

   // A split happens only at the delimiter, outside quotes, at depth zero
   a_split_at_top_level: assert property (@(posedge clock) disable iff (reset)
      ends |-> ((item.in_byte == delimiter) && !quote_new && (depth_new == '0)))
      else $error("split outside top level");

endmodule

/* rtl/qbs_out_stage.sv */
// Result register of the splitter: holds a finished item until the consumer takes it.
// Depends on qbs_pkg.
module qbs_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     s1_valid,
   input  qbs_pkg::rsp_payload_type result,
   output logic                     take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output qbs_pkg::rsp_payload_type rsp_payload
);

   logic                     valid_ff;
   logic                     valid_in;
   qbs_pkg::rsp_payload_type payload_ff;

   // Move an item in when the register is empty or being drained
   assign take = s1_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the result
   always_ff @(posedge clock) begin
      if (take) begin
         payload_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

/* rtl/quote_bracket_aware_splitter.sv */
// Top level of the quote and bracket aware splitter.
// Depends on qbs_pkg, qbs_in_stage, qbs_core and qbs_out_stage.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | req_payload  (in_byte, is_last)
//   rsp     | out       | rsp_valid/stall    | rsp_payload  (out_byte, ends_piece,
//           |           |                    |   piece_index, piece_count, done_res)
//   csr     | in        | csr_valid/ready    | csr_data     (delimiter_char)
//
// One byte per cycle while the result side does not stall; each item passes through two
// registers, the input register and then the result register.
// The split state updates as an item moves from the input register to the result register.
// Reset (synchronous) empties both registers, clears the split state and sets the
// delimiter to semicolon. A stalled result holds and the input stalls once its register
// is full.
module quote_bracket_aware_splitter #(
   parameter int DEPTH_BITS = qbs_pkg::DEPTH_BITS_DEF,
   parameter int COUNT_BITS = qbs_pkg::COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  qbs_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output qbs_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [7:0]               csr_data
);

   logic                     s1_valid;
   qbs_pkg::req_payload_type s1_payload;
   logic                     take;
   qbs_pkg::rsp_payload_type result;
   logic [7:0]               delim_ff;
   logic [7:0]               delim_in;

   // Delimiter register, always writable
   assign csr_ready = 1'b1;
   assign delim_in  = (csr_valid && csr_ready) ? csr_data : delim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= qbs_pkg::DELIM_RESET;
      end else begin
         delim_ff <= delim_in;
      end
   end

   qbs_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .take        (take),
      .s1_valid    (s1_valid),
      .s1_payload  (s1_payload)
   );

   qbs_core #(
      .DEPTH_BITS (DEPTH_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (take),
      .item      (s1_payload),
      .delimiter (delim_ff),
      .result    (result)
   );

   qbs_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid),
      .result      (result),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* tb/sv/quote_bracket_aware_splitter_tb.sv */
// Self-checking testbench for the quote and bracket aware splitter.
// Depends on qbs_pkg and quote_bracket_aware_splitter; predicts every result in step.
// Runs directed strings, random strings per delimiter setting and depth limit strings.
module quote_bracket_aware_splitter_tb;

   localparam int DEPTH_BITS = qbs_pkg::DEPTH_BITS_DEF;
   localparam int COUNT_BITS = qbs_pkg::COUNT_BITS_DEF;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned HOLD_AT_RESULT = 200;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_TOP = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_BOT = {1'b1, {(DEPTH_BITS-1){1'b0}}};
   localparam logic [32:0] COUNT_TOP = (33'd1 << COUNT_BITS) - 33'd1;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_X = 8'h78;

   typedef logic [7:0] char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   qbs_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   qbs_pkg::rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_data = '0;

   // Items waiting to be offered and results waiting to arrive
   qbs_pkg::req_payload_type pending_bytes[$];
   qbs_pkg::rsp_payload_type expected_pieces[$];
   int unsigned queued_total = 0;
   int unsigned results_seen = 0;
   int unsigned fault_count = 0;
   int unsigned cycle_count = 0;

   // Idle controls for each side
   logic tx_idle_on = 1'b1;
   logic rx_idle_on = 1'b1;
   int unsigned tx_gap_left = 0;
   int unsigned rx_stall_left = 0;
   logic hold_done = 1'b0;
   qbs_pkg::rsp_payload_type oldest_piece;

   // Predicted split state
   logic [7:0] split_delim;
   logic [7:0] last_byte;
   logic [7:0] older_byte;
   logic [1:0] bytes_seen;
   logic in_quotes;
   logic signed [DEPTH_BITS-1:0] depth_lvl;
   logic [COUNT_BITS-1:0] piece_now;

   quote_bracket_aware_splitter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [15:0] to_out_field(logic [32:0] v);
      return (v > 33'h0FFFF) ? 16'hFFFF : v[qbs_pkg::OUT_BITS-1:0];
   endfunction

   function automatic void clear_split_state();
      last_byte = '0;
      older_byte = '0;
      bytes_seen = '0;
      in_quotes = 1'b0;
      depth_lvl = '0;
      piece_now = '0;
   endfunction

   // Advance the split state by one byte and return the result it causes
   function automatic qbs_pkg::rsp_payload_type split_byte(qbs_pkg::req_payload_type it);
      qbs_pkg::rsp_payload_type r;
      logic flip;
      logic [32:0] total;
      r = '0;
      r.out_byte = it.in_byte;
      r.piece_index = to_out_field(33'(piece_now));
      r.done_res = it.is_last;
      if (it.in_byte == qbs_pkg::CHAR_DQUOTE || it.in_byte == qbs_pkg::CHAR_SQUOTE
          || it.in_byte == qbs_pkg::CHAR_BACKTICK) begin
         // a single backslash escapes, a doubled one does not
         if (bytes_seen == '0 || last_byte != qbs_pkg::CHAR_BACKSLASH) flip = 1'b1;
         else flip = (bytes_seen == qbs_pkg::POS_FULL
                      && older_byte == qbs_pkg::CHAR_BACKSLASH);
         if (flip) in_quotes = !in_quotes;
      end
      if (!in_quotes) begin
         if ((it.in_byte == qbs_pkg::CHAR_LPAREN || it.in_byte == qbs_pkg::CHAR_LBRACE
              || it.in_byte == qbs_pkg::CHAR_LBRACKET) && depth_lvl != DEPTH_TOP)
            depth_lvl = depth_lvl + 1'b1;
         if ((it.in_byte == qbs_pkg::CHAR_RPAREN || it.in_byte == qbs_pkg::CHAR_RBRACE
              || it.in_byte == qbs_pkg::CHAR_RBRACKET) && depth_lvl != DEPTH_BOT)
            depth_lvl = depth_lvl - 1'b1;
         if (it.in_byte == split_delim && depth_lvl == '0) begin
            r.ends_piece = 1'b1;
            if (!it.is_last && piece_now != '1) piece_now = piece_now + 1'b1;
         end
      end
      if (it.is_last) begin
         total = 33'(piece_now) + 33'd1;
         if (total > COUNT_TOP) total = COUNT_TOP;
         r.piece_count = to_out_field(total);
         clear_split_state();
      end else begin
         older_byte = last_byte;
         last_byte = it.in_byte;
         if (bytes_seen != qbs_pkg::POS_FULL) bytes_seen = bytes_seen + 1'b1;
      end
      return r;
   endfunction

   // Track the delimiter register
   always @(posedge clock) begin
      if (reset) begin
         split_delim <= qbs_pkg::DELIM_RESET;
      end else if (csr_valid && csr_ready) begin
         split_delim <= csr_data;
      end
   end

   // Driver: predict each accepted item, then offer the next one after a gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap_left <= 0;
         clear_split_state();
      end else begin
         if (req_valid && !req_stall) expected_pieces.push_back(split_byte(req_payload));
         if (!req_valid || !req_stall) begin
            if (tx_gap_left != 0) begin
               tx_gap_left <= tx_gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_payload <= pending_bytes.pop_front();
               req_valid <= 1'b1;
               tx_gap_left <= tx_idle_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         if (fault_count < 10)
            $display("mismatch in %s at result %0d: expected %0h, got %0h",
                     field, results_seen, want, got);
         fault_count++;
      end
   endtask

   // Monitor: check each accepted result, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_pieces.size() == 0) begin
               if (fault_count < 10)
                  $display("result %0d arrived with nothing expected", results_seen);
               fault_count++;
            end else begin
               oldest_piece = expected_pieces.pop_front();
               check_field("out_byte", 16'(rsp_payload.out_byte),
                           16'(oldest_piece.out_byte));
               check_field("ends_piece", 16'(rsp_payload.ends_piece),
                           16'(oldest_piece.ends_piece));
               check_field("piece_index", rsp_payload.piece_index, oldest_piece.piece_index);
               check_field("piece_count", rsp_payload.piece_count, oldest_piece.piece_count);
               check_field("done_res", 16'(rsp_payload.done_res),
                           16'(oldest_piece.done_res));
            end
         end
         // hold off once for a long stretch so the block fills and stalls its input
         if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
            hold_done <= 1'b1;
            rx_stall_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rx_stall_left <= rx_idle_on ? pick_gap() : 0;
         end
      end
   end

   // Queue one string, flagging its final byte
   task automatic queue_string(input char_type text[$]);
      qbs_pkg::req_payload_type it;
      foreach (text[k]) begin
         it.in_byte = text[k];
         it.is_last = (k == text.size() - 1);
         pending_bytes.push_back(it);
         queued_total++;
      end
   endtask

   // Bias characters toward the ones that steer the splitter
   function automatic char_type pick_char(char_type delim);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 18) return delim;
      if (r < 33) begin
         case ($urandom_range(2))
            0: return qbs_pkg::CHAR_DQUOTE;
            1: return qbs_pkg::CHAR_SQUOTE;
            default: return qbs_pkg::CHAR_BACKTICK;
         endcase
      end
      if (r < 45) return qbs_pkg::CHAR_BACKSLASH;
      if (r < 65) begin
         case ($urandom_range(5))
            0: return qbs_pkg::CHAR_LPAREN;
            1: return qbs_pkg::CHAR_LBRACE;
            2: return qbs_pkg::CHAR_LBRACKET;
            3: return qbs_pkg::CHAR_RPAREN;
            4: return qbs_pkg::CHAR_RBRACE;
            default: return qbs_pkg::CHAR_RBRACKET;
         endcase
      end
      if (r < 72) return (r < 69) ? qbs_pkg::DELIM_RESET : CHAR_COMMA;
      return char_type'($urandom_range(255));
   endfunction

   // Drive the depth near or past its upper or lower limit; no delimiter there splits
   task automatic queue_nesting(logic going_up, char_type delim);
      char_type text[$];
      int unsigned n;
      n = $urandom_range(131, 126);
      repeat (n) begin
         case ($urandom_range(2))
            0: text.push_back(going_up ? qbs_pkg::CHAR_LPAREN : qbs_pkg::CHAR_RPAREN);
            1: text.push_back(going_up ? qbs_pkg::CHAR_LBRACE : qbs_pkg::CHAR_RBRACE);
            default: text.push_back(going_up ? qbs_pkg::CHAR_LBRACKET
                                             : qbs_pkg::CHAR_RBRACKET);
         endcase
      end
      text.push_back(delim);
      text.push_back(going_up ? qbs_pkg::CHAR_RPAREN : qbs_pkg::CHAR_LPAREN);
      text.push_back(delim);
      text.push_back(CHAR_X);
      queue_string(text);
   endtask

   // Mostly well-formed strings with random content, some noise and deep nesting
   task automatic queue_random(int unsigned n_items, char_type delim);
      char_type text[$];
      int unsigned start;
      int unsigned kind;
      int unsigned len;
      start = queued_total;
      while (queued_total - start < n_items) begin
         text.delete();
         kind = $urandom_range(99);
         if (kind < 2) begin
            queue_nesting(kind == 0, delim);
         end else begin
            len = (kind < 85) ? $urandom_range(16, 1) : $urandom_range(10, 1);
            repeat (len) text.push_back((kind < 85) ? pick_char(delim)
                                                    : char_type'($urandom_range(255)));
            queue_string(text);
         end
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_pieces.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_delim(logic [7:0] value);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // Timeout
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[quote_bracket_aware_splitter] ERROR");
      $finish;
   end

   // Stimulus sequence
   initial begin
      char_type text[$];
      char_type delim_list[5];
      delim_list = '{8'h00, 8'hFF, qbs_pkg::CHAR_LPAREN, qbs_pkg::CHAR_DQUOTE, CHAR_COMMA};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // quote on the first byte, delimiter inside and outside quotes
      text = '{qbs_pkg::CHAR_DQUOTE, qbs_pkg::DELIM_RESET, qbs_pkg::CHAR_DQUOTE,
               qbs_pkg::DELIM_RESET, CHAR_X};
      queue_string(text);
      // escaped quote on the second byte, trailing delimiter
      text = '{qbs_pkg::CHAR_BACKSLASH, qbs_pkg::CHAR_DQUOTE, qbs_pkg::DELIM_RESET};
      queue_string(text);
      // doubled backslash does not escape
      text = '{qbs_pkg::CHAR_BACKSLASH, qbs_pkg::CHAR_BACKSLASH, qbs_pkg::CHAR_SQUOTE,
               qbs_pkg::DELIM_RESET, qbs_pkg::CHAR_SQUOTE};
      queue_string(text);
      // unbalanced closer blocks the split until balanced again
      text = '{qbs_pkg::CHAR_RPAREN, qbs_pkg::DELIM_RESET, qbs_pkg::CHAR_LPAREN,
               qbs_pkg::DELIM_RESET, qbs_pkg::CHAR_BACKTICK, qbs_pkg::CHAR_BACKTICK};
      queue_string(text);
      // zero byte is ordinary, all-ones byte too
      text = '{8'h00, qbs_pkg::DELIM_RESET, 8'hFF};
      queue_string(text);
      // single-byte string that is a delimiter
      text = '{qbs_pkg::DELIM_RESET};
      queue_string(text);
      wait_drained();

      // random strings at the reset delimiter, depth limits both ways
      queue_nesting(1'b1, qbs_pkg::DELIM_RESET);
      queue_nesting(1'b0, qbs_pkg::DELIM_RESET);
      queue_random(250, qbs_pkg::DELIM_RESET);
      wait_drained();

      // other delimiters, extremes and bracket or quote delimiters among them
      for (int i = 0; i < 5; i++) begin
         write_delim(delim_list[i]);
         tx_idle_on = (i != 4);
         rx_idle_on = (i != 4);
         queue_random(100, delim_list[i]);
         wait_drained();
      end

      write_delim(qbs_pkg::DELIM_RESET);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      queue_random(60, qbs_pkg::DELIM_RESET);
      wait_drained();
      repeat (10) @(posedge clock);

      if (expected_pieces.size() != 0) begin
         $display("%0d results never arrived", expected_pieces.size());
         fault_count += expected_pieces.size();
      end
      if (fault_count == 0) begin
         $display("[quote_bracket_aware_splitter] OK");
      end else begin
         $display("[quote_bracket_aware_splitter] ERROR");
      end
      $finish;
   end

endmodule
